### src/i2c_register_access_master_core_defines.svh
// Assertion macros shared by the checker of the I2C register access master.
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH

// Property checked on every rising clock edge, skipped while reset is high.
`define I2CRA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("i2cra assertion failed");

// Property checked on every rising clock edge, reset included.
`define I2CRA_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("i2cra assertion failed");

`endif

### src/i2cra_pkg.sv
// Types, codes and constants of the I2C register access master.
package i2cra_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [1:0] CSR_DEV_WRITE   = 2'd1;
   localparam logic [1:0] CSR_DEV_READ    = 2'd2;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
   localparam logic [7:0]  DEV_WRITE_RESET   = 8'd124;
   localparam logic [7:0]  DEV_READ_RESET    = 8'd125;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_WRITE,
      OP_READ,
      OP_NONE
   } op_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_START0  = 5'd1,
      PH_START1  = 5'd2,
      PH_START2  = 5'd3,
      PH_START3  = 5'd4,
      PH_RSTART0 = 5'd5,
      PH_RSTART1 = 5'd6,
      PH_RSTART2 = 5'd7,
      PH_RSTART3 = 5'd8,
      PH_TXLO    = 5'd9,
      PH_TXHI    = 5'd10,
      PH_ACKLO   = 5'd11,
      PH_ACKHI   = 5'd12,
      PH_RXHI    = 5'd13,
      PH_RXLO    = 5'd14,
      PH_NKLO    = 5'd15,
      PH_NKHI    = 5'd16,
      PH_NKTAIL  = 5'd17,
      PH_STOP0   = 5'd18,
      PH_STOP1   = 5'd19,
      PH_STOP2   = 5'd20,
      PH_STOP3   = 5'd21,
      PH_GAP     = 5'd22
   } phase_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  reg_addr;
      logic [7:0]  write_data;
      logic        sda_sense;
      logic        scl_sense;
   } item_type;

   typedef struct packed {
      logic        scl_pull_low;
      logic        sda_pull_low;
      logic        busy_res;
      logic        done_res;
      logic [7:0]  read_byte;
      logic [2:0]  nack_stage;
      logic [1:0]  frame_errors;
   } result_type;

   typedef struct packed {
      logic        wr_en;
      logic [1:0]  index;
      logic [15:0] wdata;
   } csr_write_type;

endpackage

### src/i2cra_fifo.sv
// Small first-in first-out queue of registers with full and empty flags.
module i2cra_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### src/i2cra_front.sv
// Front end: decodes the command of each incoming item into an operation.
module i2cra_front (
   input  logic                req_push,
   input  logic [1:0]          req_cmd,
   input  logic [7:0]          req_reg_addr,
   input  logic [7:0]          req_write_data,
   input  logic                req_sda_sense,
   input  logic                req_scl_sense,
   output logic                q_push,
   output i2cra_pkg::item_type q_item
);
   import i2cra_pkg::*;

   op_type op;

   always_comb begin
      unique case (req_cmd)
         CMD_TICK:  op = OP_TICK;
         CMD_WRITE: op = OP_WRITE;
         CMD_READ:  op = OP_READ;
         default:   op = OP_NONE;
      endcase
   end

   assign q_push            = req_push;
   assign q_item.op         = op;
   assign q_item.reg_addr   = req_reg_addr;
   assign q_item.write_data = req_write_data;
   assign q_item.sda_sense  = req_sda_sense;
   assign q_item.scl_sense  = req_scl_sense;

endmodule

### src/i2cra_back.sv
// Back end: bus phase sequencer and configuration registers.
module i2cra_back (
   input  logic                     clock,
   input  logic                     reset,
   input  i2cra_pkg::csr_write_type csr,
   input  logic                     in_empty,
   input  i2cra_pkg::item_type      in_item,
   output logic                     in_pop,
   input  logic                     out_full,
   output logic                     out_push,
   output i2cra_pkg::result_type    out_result
);
   import i2cra_pkg::*;

   logic [15:0] hp_ff;
   logic [7:0]  dwb_ff, drb_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [1:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic        read_ff, read_in;
   logic [2:0]  nack_ff, nack_in;
   logic [1:0]  frame_ff, frame_in;
   logic [7:0]  recv_ff, recv_in;

   logic        fire;
   logic        start_hit;
   logic        done;
   logic [16:0] tick_next;
   logic        phase_end;
   logic [3:0]  bit_next;
   logic        scl_drv, sda_drv;
   logic        bit_low;

   assign fire      = ~in_empty & ~out_full;
   assign in_pop    = fire;
   assign out_push  = fire;
   assign tick_next = {1'b0, tick_ff} + 17'd1;
   // a zero half period ends every phase on its first tick, as one does
   assign phase_end = (tick_next >= {1'b0, hp_ff});
   assign bit_next  = bit_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff  <= HALF_PERIOD_RESET;
         dwb_ff <= DEV_WRITE_RESET;
         drb_ff <= DEV_READ_RESET;
      end else if (csr.wr_en) begin
         case (csr.index)
            CSR_HALF_PERIOD: hp_ff  <= csr.wdata;
            CSR_DEV_WRITE:   dwb_ff <= csr.wdata[7:0];
            CSR_DEV_READ:    drb_ff <= csr.wdata[7:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      read_in   = read_ff;
      nack_in   = nack_ff;
      frame_in  = frame_ff;
      recv_in   = recv_ff;
      start_hit = 1'b0;
      done      = 1'b0;
      if (fire) begin
         unique case (in_item.op)
            OP_WRITE, OP_READ: begin
               if (phase_ff == PH_IDLE) begin
                  start_hit = 1'b1;
                  addr_in   = in_item.reg_addr;
                  data_in   = in_item.write_data;
                  read_in   = (in_item.op == OP_READ);
                  nack_in   = 3'd0;
                  tick_in   = 16'd0;
                  bit_in    = 4'd0;
                  byte_in   = 2'd0;
                  phase_in  = PH_START0;
               end
            end
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (!phase_end) begin
                     tick_in = tick_next[15:0];
                  end else begin
                     tick_in = 16'd0;
                     unique case (phase_ff)
                        PH_START0:  phase_in = PH_START1;
                        PH_START1:  phase_in = PH_START2;
                        PH_START2:  phase_in = PH_START3;
                        PH_START3: begin
                           byte_in  = 2'd0;
                           shift_in = dwb_ff;
                           bit_in   = 4'd0;
                           phase_in = PH_TXLO;
                        end
                        PH_RSTART0: phase_in = PH_RSTART1;
                        PH_RSTART1: phase_in = PH_RSTART2;
                        PH_RSTART2: phase_in = PH_RSTART3;
                        PH_RSTART3: begin
                           byte_in  = 2'd2;
                           shift_in = drb_ff;
                           bit_in   = 4'd0;
                           phase_in = PH_TXLO;
                        end
                        PH_TXLO:    phase_in = PH_TXHI;
                        PH_TXHI: begin
                           shift_in = {shift_ff[6:0], 1'b0};
                           bit_in   = bit_next;
                           phase_in = (bit_next >= 4'd8) ? PH_ACKLO : PH_TXLO;
                        end
                        PH_ACKLO:   phase_in = PH_ACKHI;
                        PH_ACKHI: begin
                           // record NACK and keep going
                           if (in_item.sda_sense) begin
                              nack_in = {1'b0, byte_ff} + (read_ff ? 3'd4 : 3'd1);
                           end
                           if (byte_ff == 2'd0) begin
                              byte_in  = 2'd1;
                              shift_in = addr_ff;
                              bit_in   = 4'd0;
                              phase_in = PH_TXLO;
                           end else if (!read_ff) begin
                              if (byte_ff == 2'd1) begin
                                 byte_in  = 2'd2;
                                 shift_in = data_ff;
                                 bit_in   = 4'd0;
                                 phase_in = PH_TXLO;
                              end else begin
                                 phase_in = PH_STOP0;
                              end
                           end else if (byte_ff == 2'd1) begin
                              phase_in = PH_RSTART0;
                           end else begin
                              shift_in = 8'd0;
                              bit_in   = 4'd0;
                              phase_in = PH_RXHI;
                           end
                        end
                        PH_RXHI: begin
                           shift_in = {shift_ff[6:0], in_item.sda_sense};
                           phase_in = PH_RXLO;
                        end
                        PH_RXLO: begin
                           bit_in = bit_next;
                           if (bit_next >= 4'd8) begin
                              recv_in  = shift_ff;
                              phase_in = PH_NKLO;
                           end else begin
                              phase_in = PH_RXHI;
                           end
                        end
                        PH_NKLO:    phase_in = PH_NKHI;
                        PH_NKHI:    phase_in = PH_NKTAIL;
                        PH_NKTAIL:  phase_in = PH_STOP0;
                        PH_STOP0:   phase_in = PH_STOP1;
                        PH_STOP1:   phase_in = PH_STOP2;
                        PH_STOP2:   phase_in = PH_STOP3;
                        PH_STOP3: begin
                           // count each bus line still held low
                           frame_in = {1'b0, ~in_item.scl_sense}
                                    + {1'b0, ~in_item.sda_sense};
                           bit_in   = 4'd0;
                           phase_in = PH_GAP;
                        end
                        PH_GAP: begin
                           bit_in = bit_next;
                           if (bit_next >= 4'd4) begin
                              bit_in   = 4'd0;
                              phase_in = PH_IDLE;
                              done     = 1'b1;
                           end
                        end
                        default:    phase_in = PH_IDLE;
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // line drive of the phase executed by this item
   assign bit_low = ~shift_ff[7];

   always_comb begin
      scl_drv = 1'b0;
      sda_drv = 1'b0;
      unique case (phase_ff)
         PH_START2:  sda_drv = 1'b1;
         PH_START3:  begin scl_drv = 1'b1; sda_drv = 1'b1; end
         PH_RSTART0: scl_drv = 1'b1;
         PH_RSTART2: sda_drv = 1'b1;
         PH_RSTART3: begin scl_drv = 1'b1; sda_drv = 1'b1; end
         PH_TXLO:    begin scl_drv = 1'b1; sda_drv = bit_low; end
         PH_TXHI:    sda_drv = bit_low;
         PH_ACKLO:   scl_drv = 1'b1;
         PH_RXLO:    scl_drv = 1'b1;
         PH_NKLO:    scl_drv = 1'b1;
         PH_NKTAIL:  scl_drv = 1'b1;
         PH_STOP0:   scl_drv = 1'b1;
         PH_STOP1:   begin scl_drv = 1'b1; sda_drv = 1'b1; end
         PH_STOP2:   sda_drv = 1'b1;
         default: ;
      endcase
      // an accepted request shows the first start phase: both lines released
      out_result.scl_pull_low = scl_drv & ~start_hit;
      out_result.sda_pull_low = sda_drv & ~start_hit;
      out_result.busy_res     = (phase_in != PH_IDLE);
      out_result.done_res     = done;
      out_result.read_byte    = recv_in;
      out_result.nack_stage   = nack_in;
      out_result.frame_errors = frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= 16'd0;
         bit_ff   <= 4'd0;
         byte_ff  <= 2'd0;
         shift_ff <= 8'd0;
         read_ff  <= 1'b0;
         nack_ff  <= 3'd0;
         frame_ff <= 2'd0;
         recv_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         read_ff  <= read_in;
         nack_ff  <= nack_in;
         frame_ff <= frame_in;
         recv_ff  <= recv_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      data_ff <= data_in;
   end

endmodule

### src/i2c_register_access_master_core.sv
// An accepted item is registered in the item queue, executed by the sequencer and
// registered in the result queue, whose head drives the rsp_ ports. Throughput:
// one queued item per cycle while the result queue has room.
// Both queues hold QUEUE_DEPTH items each.
// Synchronous reset empties both queues, sets the bus idle and restores the
// configuration registers to their reset values.
module i2c_register_access_master_core #(
   parameter int QUEUE_DEPTH = i2cra_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_sense,
   input  logic        req_scl_sense,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_scl_pull_low,
   output logic        rsp_sda_pull_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,
   output logic [2:0]  rsp_nack_stage,
   output logic [1:0]  rsp_frame_errors,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import i2cra_pkg::*;

   item_type      front_item, back_item;
   result_type    back_result, rsp_result;
   csr_write_type csr;
   logic          front_push;
   logic          item_empty, item_pop;
   logic          res_full, res_push;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   i2cra_front u_front (
      .req_push       (req_push),
      .req_cmd        (req_cmd),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .req_sda_sense  (req_sda_sense),
      .req_scl_sense  (req_scl_sense),
      .q_push         (front_push),
      .q_item         (front_item)
   );

   i2cra_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(item_type))
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_item),
      .full  (req_full),
      .pop   (item_pop),
      .rdata (back_item),
      .empty (item_empty)
   );

   i2cra_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .in_empty   (item_empty),
      .in_item    (back_item),
      .in_pop     (item_pop),
      .out_full   (res_full),
      .out_push   (res_push),
      .out_result (back_result)
   );

   i2cra_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(result_type))
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (back_result),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (rsp_result),
      .empty (rsp_empty)
   );

   assign rsp_scl_pull_low = rsp_result.scl_pull_low;
   assign rsp_sda_pull_low = rsp_result.sda_pull_low;
   assign rsp_busy_res     = rsp_result.busy_res;
   assign rsp_done_res     = rsp_result.done_res;
   assign rsp_read_byte    = rsp_result.read_byte;
   assign rsp_nack_stage   = rsp_result.nack_stage;
   assign rsp_frame_errors = rsp_result.frame_errors;

endmodule

### src/i2cra_checker.sv
// Port-level checks of the I2C register access master, bound to the top level.
`include "i2c_register_access_master_core_defines.svh"

module i2cra_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_scl_pull_low,
   input logic       rsp_sda_pull_low,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [2:0] rsp_nack_stage,
   input logic [1:0] rsp_frame_errors
);

   // queues come out of reset empty
   `I2CRA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty && !req_full)

   // the end of the idle gap leaves the bus idle
   `I2CRA_ASSERT(a_done_idle, clock, reset, !rsp_empty && rsp_done_res |-> !rsp_busy_res)

   // an idle result never drives a line
   `I2CRA_ASSERT(a_idle_released, clock, reset,
      !rsp_empty && !rsp_busy_res |-> !rsp_scl_pull_low && !rsp_sda_pull_low)

   `I2CRA_ASSERT(a_status_range, clock, reset,
      !rsp_empty |-> rsp_nack_stage != 3'd7 && rsp_frame_errors != 2'd3)

   // a waiting result stays until taken
   `I2CRA_ASSERT(a_result_holds, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty)

endmodule

bind i2c_register_access_master_core i2cra_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_scl_pull_low (rsp_scl_pull_low),
   .rsp_sda_pull_low (rsp_sda_pull_low),
   .rsp_busy_res     (rsp_busy_res),
   .rsp_done_res     (rsp_done_res),
   .rsp_nack_stage   (rsp_nack_stage),
   .rsp_frame_errors (rsp_frame_errors)
);
